// ----- src/inverse_cdf_filter_sampler_defines.svh -----
// Assertion macros shared by the inverse CDF sampler modules.
// Expects clk_i and rst_ni in the scope of every use.
`ifndef INVERSE_CDF_FILTER_SAMPLER_DEFINES_SVH
`define INVERSE_CDF_FILTER_SAMPLER_DEFINES_SVH

// Checks a property on every rising clock edge outside reset.
`define ICDF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Checks that a condition in one cycle implies another in the next cycle.
`define ICDF_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// ----- src/icdf_pkg.sv -----
// Package of the inverse CDF filter sampler: payload types, codes, constants
// and the command and status structs between controller and datapath.
`default_nettype none

package icdf_pkg;

  // Table size default.
  localparam int BINS_DEFAULT = 64;

  // Field widths.
  localparam int Q_BITS       = 16;
  localparam int VAL_W        = 17;
  localparam int X_W          = 16;
  localparam int EIDX_W       = 7;
  localparam int OFF_W        = 16;
  localparam int CFG_W        = 15;
  localparam int MODE_W       = 2;
  localparam int CFG_IDX_W    = 2;

  // Fixed point constants.
  localparam logic [VAL_W-1:0] ONE_Q16 = 17'h10000;
  localparam logic [CFG_W-1:0] MAG_MAX = 15'h7FFF;

  // Item commands.
  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  // Filter modes.
  localparam logic [MODE_W-1:0] MODE_DIRAC = 2'd0;
  localparam logic [MODE_W-1:0] MODE_BOX   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TABLE = 2'd2;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BIN_SIZE    = 2'd2;

  // Register reset values.
  localparam logic [MODE_W-1:0] FILTER_MODE_RST = MODE_TABLE;
  localparam logic [CFG_W-1:0]  HALF_WIDTH_RST  = 15'd4096;
  localparam logic [CFG_W-1:0]  BIN_SIZE_RST    = 15'd65;

  // Input item.
  typedef struct packed {
    logic              cmd;
    logic [EIDX_W-1:0] entry_index;
    logic [VAL_W-1:0]  entry_value;
    logic [X_W-1:0]    uniform_x;
  } icdf_in_t;

  // Result item.
  typedef struct packed {
    logic signed [OFF_W-1:0] offset;
    logic                    is_sample;
  } icdf_out_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic start;
    logic srch;
    logic setup;
    logic div;
    logic mul;
    logic load_out;
  } icdf_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic hit;
    logic need_div;
    logic div_last;
  } icdf_status_t;

endpackage

`default_nettype wire

// ----- src/icdf_ctrl.sv -----
// Sequencer of the inverse CDF sampler: walks each item through those of the
// search, divide, multiply and result stages it needs. Uses icdf_pkg and the assertion macros.
`default_nettype none
`include "inverse_cdf_filter_sampler_defines.svh"

module icdf_ctrl (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           in_valid_i,
  input  wire                           in_cmd_i,
  output logic                          in_ready_o,
  output logic                          out_valid_o,
  input  wire                           out_ready_i,
  input  wire [icdf_pkg::MODE_W-1:0]    mode_i,
  input  wire icdf_pkg::icdf_status_t   status_i,
  output icdf_pkg::icdf_cmd_t           cmd_o
);
  import icdf_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SRCH,
    ST_SETUP,
    ST_DIV,
    ST_MUL,
    ST_FIN
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   out_free;
  logic   setup_div;

  // The output register can take a new result when empty or being drained.
  assign out_free = !out_valid_q || out_ready_i;

  // Setup of a rising bin whose point lies below its upper edge.
  assign setup_div = (state_q == ST_SETUP) && status_i.need_div;

  // Commands decoded from the state.
  always_comb begin
    cmd_o          = '0;
    cmd_o.start    = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.srch     = (state_q == ST_SRCH);
    cmd_o.setup    = (state_q == ST_SETUP);
    cmd_o.div      = (state_q == ST_DIV);
    cmd_o.mul      = (state_q == ST_MUL);
    cmd_o.load_out = (state_q == ST_FIN) && out_free;
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  // State register and output valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            if (in_cmd_i == CMD_LOAD) begin
              state_q <= ST_FIN;
            end else begin
              unique case (mode_i)
                MODE_BOX:   state_q <= ST_MUL;
                MODE_TABLE: state_q <= ST_SRCH;
                default:    state_q <= ST_FIN;
              endcase
            end
          end
        end
        ST_SRCH: begin
          if (status_i.hit) begin
            state_q <= ST_SETUP;
          end
        end
        ST_SETUP: begin
          state_q <= status_i.need_div ? ST_DIV : ST_MUL;
        end
        ST_DIV: begin
          if (status_i.div_last) begin
            state_q <= ST_MUL;
          end
        end
        ST_MUL: begin
          state_q <= ST_FIN;
        end
        ST_FIN: begin
          if (out_free) begin
            state_q     <= ST_IDLE;
            out_valid_q <= 1'b1;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // A result never overwrites one that is still waiting.
  `ICDF_ASSERT(a_no_overwrite, cmd_o.load_out |-> out_free, "result overwritten")
  // A bin that needs interpolation goes through the divider.
  `ICDF_ASSERT_NEXT(a_div_entry, setup_div, state_q == ST_DIV, "divider skipped")
  // Input is only taken while no result is being prepared.
  `ICDF_ASSERT(a_no_accept_busy, (state_q != ST_IDLE) |-> !cmd_o.start, "accept while busy")

endmodule

`default_nettype wire

// ----- src/icdf_dp.sv -----
// Datapath of the inverse CDF sampler: table memory, bin search, serial
// divider, shared multiplier and output register. Uses icdf_pkg and macros.
`default_nettype none
`include "inverse_cdf_filter_sampler_defines.svh"

module icdf_dp #(
  parameter int BINS = icdf_pkg::BINS_DEFAULT
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire icdf_pkg::icdf_in_t      in_data_i,
  input  wire [icdf_pkg::CFG_W-1:0]    half_width_i,
  input  wire [icdf_pkg::CFG_W-1:0]    bin_size_i,
  input  wire [icdf_pkg::MODE_W-1:0]   mode_i,
  input  wire icdf_pkg::icdf_cmd_t     cmd_i,
  output icdf_pkg::icdf_status_t       status_o,
  output icdf_pkg::icdf_out_t          out_data_o
);
  import icdf_pkg::*;

  localparam int IW  = $clog2(BINS);
  localparam int AW  = $clog2(BINS + 1);
  localparam int TW  = IW + Q_BITS + 1;
  localparam int PW  = CFG_W + TW;
  localparam int MW  = PW - Q_BITS;
  localparam int DCW = $clog2(Q_BITS);

  logic [VAL_W-1:0] cdf_mem [BINS+1];
  logic [VAL_W-1:0] rdata_q;
  logic [AW-1:0]    raddr;

  logic [X_W-1:0]   xf_q;
  logic             neg_q;
  logic             zero_q;
  logic             box_q;
  logic             is_sample_q;
  logic [IW-1:0]    idx_q;
  logic [VAL_W-1:0] hi_q;
  logic [VAL_W-1:0] rem_q;
  logic [VAL_W-1:0] rise_q;
  logic [Q_BITS-1:0] quo_q;
  logic [DCW-1:0]   dcnt_q;
  logic [TW-1:0]    t_q;
  logic [PW-1:0]    prod_q;
  icdf_out_t        out_q;

  logic             hit;
  logic             srch_miss;
  logic [VAL_W-1:0] twox;
  logic [VAL_W-1:0] box_d;
  logic [VAL_W-1:0] xf_ext;
  logic [VAL_W-1:0] rise;
  logic [VAL_W-1:0] num_raw;
  logic [VAL_W-1:0] num;
  logic             rising;
  logic             need_div;
  logic [TW-1:0]    t_base;
  logic [VAL_W:0]   rem_sh;
  logic             rem_ge;
  logic [VAL_W-1:0] rem_n;
  logic [Q_BITS-1:0] quo_n;
  logic             div_last;
  logic [CFG_W-1:0] mul_a;
  logic [MW-1:0]    mag_full;
  logic [CFG_W-1:0] mag_sat;
  logic [OFF_W-1:0] off_mag;
  logic [OFF_W-1:0] off_val;
  logic             load_ok;

  // Input folding: xf is 2x modulo one, and the sign follows the lower half.
  assign twox  = {in_data_i.uniform_x, 1'b0};
  assign box_d = in_data_i.uniform_x[X_W-1] ? (twox - ONE_Q16) : (ONE_Q16 - twox);

  // Search ends on the first entry above xf, or is clamped at the last bin.
  assign hit = (({1'b0, xf_q}) < rdata_q) || (idx_q == IW'(BINS - 1));
  assign srch_miss = cmd_i.srch && !hit;

  // Read address: entry 1 at the start, the entry after next while searching,
  // then the lower edge of the chosen bin.
  always_comb begin
    if (cmd_i.start) begin
      raddr = AW'(1);
    end else if (cmd_i.srch && !hit) begin
      raddr = AW'(idx_q) + AW'(2);
    end else begin
      raddr = AW'(idx_q);
    end
  end

  assign load_ok = cmd_i.start && (in_data_i.cmd == CMD_LOAD) && (in_data_i.entry_index <= BINS);

  // Table memory with registered read.
  always_ff @(posedge clk_i) begin
    if (load_ok) begin
      cdf_mem[AW'(in_data_i.entry_index)] <= in_data_i.entry_value;
    end
    rdata_q <= cdf_mem[raddr];
  end

  // Bin edges and the clamped numerator of the interpolation.
  assign xf_ext   = {1'b0, xf_q};
  assign rise     = hi_q - rdata_q;
  assign num_raw  = (xf_ext > rdata_q) ? (xf_ext - rdata_q) : '0;
  assign num      = (num_raw > rise) ? rise : num_raw;
  assign rising   = hi_q > rdata_q;
  assign need_div = rising && (num != rise);
  assign t_base   = TW'({idx_q, {Q_BITS{1'b0}}});

  // One restoring division step per cycle.
  assign rem_sh   = {rem_q, 1'b0};
  assign rem_ge   = rem_sh >= {1'b0, rise_q};
  assign rem_n    = rem_ge ? VAL_W'(rem_sh - {1'b0, rise_q}) : VAL_W'(rem_sh);
  assign quo_n    = {quo_q[Q_BITS-2:0], rem_ge};
  assign div_last = (dcnt_q == DCW'(Q_BITS - 1));

  // Multiplier operand: half width for box mode, bin size for the table.
  assign mul_a = box_q ? half_width_i : bin_size_i;

  // Saturate the magnitude and apply the sign.
  assign mag_full = prod_q[PW-1:Q_BITS];
  assign mag_sat  = (mag_full > MW'(MAG_MAX)) ? MAG_MAX : mag_full[CFG_W-1:0];
  assign off_mag  = {1'b0, mag_sat};
  assign off_val  = zero_q ? '0 : (neg_q ? (OFF_W'(0) - off_mag) : off_mag);

  // Division step counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dcnt_q <= '0;
    end else if (cmd_i.setup) begin
      dcnt_q <= '0;
    end else if (cmd_i.div) begin
      dcnt_q <= dcnt_q + 1'b1;
    end
  end

  // Working registers of the datapath.
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      is_sample_q <= in_data_i.cmd;
      zero_q      <= (in_data_i.cmd == CMD_LOAD) ||
                     ((mode_i != MODE_BOX) && (mode_i != MODE_TABLE));
      box_q       <= (mode_i == MODE_BOX);
      neg_q       <= !in_data_i.uniform_x[X_W-1];
      xf_q        <= {in_data_i.uniform_x[X_W-2:0], 1'b0};
      idx_q       <= '0;
      t_q         <= TW'(box_d);
    end
    if (cmd_i.srch) begin
      if (hit) begin
        hi_q <= rdata_q;
      end else begin
        idx_q <= idx_q + 1'b1;
      end
    end
    if (cmd_i.setup) begin
      rem_q  <= num;
      rise_q <= rise;
      quo_q  <= '0;
      if (!rising) begin
        t_q <= t_base;
      end else if (!need_div) begin
        t_q <= t_base + TW'(ONE_Q16);
      end
    end
    if (cmd_i.div) begin
      rem_q <= rem_n;
      quo_q <= quo_n;
      if (div_last) begin
        t_q <= t_base + TW'(quo_n);
      end
    end
    if (cmd_i.mul) begin
      prod_q <= PW'(mul_a) * PW'(t_q);
    end
    if (cmd_i.load_out) begin
      out_q.offset    <= $signed(off_val);
      out_q.is_sample <= is_sample_q;
    end
  end

  assign status_o.hit      = hit;
  assign status_o.need_div = need_div;
  assign status_o.div_last = div_last;
  assign out_data_o        = out_q;

  // The partial remainder stays below the divisor.
  `ICDF_ASSERT(a_rem_below_rise, cmd_i.div |-> (rem_q < rise_q), "remainder out of range")
  // A search step that misses moves to the next bin.
  `ICDF_ASSERT_NEXT(a_search_advance, srch_miss, idx_q == $past(idx_q) + 1'b1, "search stalled")

endmodule

`default_nettype wire

// ----- src/inverse_cdf_filter_sampler.sv -----
// Inverse CDF filter sampler. Load items and dirac samples go from the transfer
// straight to the result, and box samples through the multiply first. Table
// samples take one table read per bin up to the bin found (1..BINS), setup, 16
// divider steps when the bin rises and the point lies below its upper edge,
// multiply and result. A new item can be taken from the cycle after a result is registered.
// Reset sets the config registers to their defaults; the table is undefined until loaded.
`default_nettype none

module inverse_cdf_filter_sampler #(
  parameter int BINS = icdf_pkg::BINS_DEFAULT
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           in_valid_i,
  output logic                          in_ready_o,
  input  wire icdf_pkg::icdf_in_t       in_data_i,
  output logic                          out_valid_o,
  input  wire                           out_ready_i,
  output icdf_pkg::icdf_out_t           out_data_o,
  input  wire                           cfg_we_i,
  input  wire [icdf_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire [icdf_pkg::CFG_W-1:0]     cfg_data_i
);
  import icdf_pkg::*;

  logic [MODE_W-1:0] filter_mode_q;
  logic [CFG_W-1:0]  half_width_q;
  logic [CFG_W-1:0]  bin_size_q;
  icdf_cmd_t         cmd;
  icdf_status_t      status;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filter_mode_q <= FILTER_MODE_RST;
      half_width_q  <= HALF_WIDTH_RST;
      bin_size_q    <= BIN_SIZE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_FILTER_MODE: filter_mode_q <= cfg_data_i[MODE_W-1:0];
        REG_HALF_WIDTH:  half_width_q  <= cfg_data_i;
        REG_BIN_SIZE:    bin_size_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Sequencer.
  icdf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_cmd_i    (in_data_i.cmd),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .mode_i      (filter_mode_q),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Datapath.
  icdf_dp #(
    .BINS (BINS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_data_i    (in_data_i),
    .half_width_i (half_width_q),
    .bin_size_i   (bin_size_q),
    .mode_i       (filter_mode_q),
    .cmd_i        (cmd),
    .status_o     (status),
    .out_data_o   (out_data_o)
  );

endmodule

`default_nettype wire

// ----- test/tb_top.sv -----
// Self-checking testbench for inverse_cdf_filter_sampler: directed corner cases, then random
// table, box and dirac traffic, with random stalls on both valid/ready channels.
// Depends on icdf_pkg and the inverse_cdf_filter_sampler top level only.
module tb_top;
  import icdf_pkg::*;

  localparam int BINS = BINS_DEFAULT;
  localparam int TAB_AW = $clog2(BINS + 1);
  localparam int WGT_AW = $clog2(BINS);
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int PHASES = 12;
  localparam int PHASE_ITEMS = 78;
  localparam int DRAIN_CYCLES = 100;

  typedef enum int {SHAPE_SMOOTH, SHAPE_PEAKED, SHAPE_NOISE, SHAPE_SHIFTED} cdf_shape_e;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  icdf_in_t             in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  icdf_out_t            out_data;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  // Items waiting to be sent and the results they are known to cause.
  icdf_in_t  items_to_send[$];
  icdf_out_t offsets_due[$];

  // Table and register copies, updated as transfers and writes happen.
  logic [VAL_W-1:0]  cdf_shadow [0:BINS];
  logic [MODE_W-1:0] mode_shadow = FILTER_MODE_RST;
  logic [CFG_W-1:0]  half_width_shadow = HALF_WIDTH_RST;
  logic [CFG_W-1:0]  bin_size_shadow = BIN_SIZE_RST;

  // Table contents as queued, used to aim samples at table values.
  logic [VAL_W-1:0] planned_cdf [0:BINS];

  int send_idle_pct = 9;
  int recv_idle_pct = 79;
  int mismatches = 0;

  inverse_cdf_filter_sampler #(.BINS(BINS)) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  always #1 clk_i = ~clk_i;

  // Saturates a magnitude to the Q4.12 range and applies the sign.
  function automatic logic [OFF_W-1:0] signed_offset(input logic [63:0] mag, input bit negate);
    logic [OFF_W-1:0] m;
    m = (mag > 64'(MAG_MAX)) ? {1'b0, MAG_MAX} : mag[OFF_W-1:0];
    return negate ? -m : m;
  endfunction

  // Applies one item to the table copy and returns the result it must produce.
  function automatic icdf_out_t sampled_result(input icdf_in_t item);
    icdf_out_t        res;
    logic [VAL_W-1:0] xf, lo, hi, rise, num, span;
    logic [63:0]      frac, mag;
    int unsigned      bin;
    bit               lower, found;
    int               i;
    res = '0;
    if (item.cmd == CMD_LOAD) begin
      // Indexes past the table are acknowledged but not stored.
      if (item.entry_index <= BINS) begin
        cdf_shadow[item.entry_index] = item.entry_value;
      end
      return res;
    end
    res.is_sample = 1'b1;
    lower = (item.uniform_x[X_W-1] == 1'b0);
    if (mode_shadow == MODE_BOX) begin
      // Distance of 2x from one, scaled by the half width.
      span = lower ? ONE_Q16 - {item.uniform_x, 1'b0} : {item.uniform_x, 1'b0} - ONE_Q16;
      mag = (64'(span) * 64'(half_width_shadow)) >> Q_BITS;
      res.offset = signed_offset(mag, lower);
    end else if (mode_shadow == MODE_TABLE) begin
      // Fold about one half, then take the first bin whose upper entry exceeds it.
      xf = {1'b0, item.uniform_x[X_W-2:0], 1'b0};
      bin = BINS - 1;
      found = 1'b0;
      for (i = 1; i <= BINS; i++) begin
        if (!found && xf < cdf_shadow[TAB_AW'(i)]) begin
          bin = i - 1;
          found = 1'b1;
        end
      end
      lo = cdf_shadow[TAB_AW'(bin)];
      hi = cdf_shadow[TAB_AW'(bin + 1)];
      frac = '0;
      // A flat or falling bin contributes no fraction; otherwise it is clamped to [0,1].
      if (hi > lo) begin
        rise = hi - lo;
        num = (xf > lo) ? xf - lo : '0;
        if (num > rise) begin
          num = rise;
        end
        frac = (64'(num) << Q_BITS) / 64'(rise);
      end
      mag = (64'(bin_size_shadow) * ((64'(bin) << Q_BITS) + frac)) >> Q_BITS;
      res.offset = signed_offset(mag, lower);
    end
    // Dirac and the unused mode leave the offset at zero.
    return res;
  endfunction

  // Input side: present queued items and predict each one at its transfer.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        offsets_due.push_back(sampled_result(in_data));
      end
      if (!in_valid || in_ready) begin
        if (items_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data <= items_to_send.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output side: stall at random and check every result transfer in order.
  always @(posedge clk_i or negedge rst_ni) begin
    icdf_out_t want;
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (offsets_due.size() == 0) begin
          $error("unexpected result: offset %0d is_sample %0b",
                 out_data.offset, out_data.is_sample);
          mismatches++;
        end else begin
          want = offsets_due.pop_front();
          if (out_data.offset !== want.offset) begin
            $error("offset: expected %0d, got %0d", want.offset, out_data.offset);
            mismatches++;
          end
          if (out_data.is_sample !== want.is_sample) begin
            $error("is_sample: expected %0b, got %0b", want.is_sample, out_data.is_sample);
            mismatches++;
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic queue_load(input int unsigned idx, input logic [VAL_W-1:0] value);
    icdf_in_t item;
    item.cmd = CMD_LOAD;
    item.entry_index = idx[EIDX_W-1:0];
    item.entry_value = value;
    item.uniform_x = X_W'($urandom);
    if (idx <= BINS) begin
      planned_cdf[TAB_AW'(idx)] = value;
    end
    items_to_send.push_back(item);
  endtask

  task automatic queue_sample(input logic [X_W-1:0] x);
    icdf_in_t item;
    item.cmd = CMD_SAMPLE;
    item.entry_index = EIDX_W'($urandom_range(127));
    item.entry_value = VAL_W'($urandom_range(ONE_Q16));
    item.uniform_x = x;
    items_to_send.push_back(item);
  endtask

  // Loads a whole table of the given shape, with stray out-of-range loads mixed in.
  task automatic queue_table(input cdf_shape_e shape);
    longint unsigned  weight [0:BINS-1];
    longint unsigned  total, run;
    logic [VAL_W-1:0] value;
    int               i;
    total = '0;
    for (i = 0; i < BINS; i++) begin
      if (shape == SHAPE_PEAKED) begin
        weight[WGT_AW'(i)] = ($urandom_range(3) != 0) ? 64'(0) : 64'($urandom_range(5000, 1));
      end else begin
        weight[WGT_AW'(i)] = 64'($urandom_range(150, 50));
      end
      total += weight[WGT_AW'(i)];
    end
    if (total == 0) begin
      weight[BINS / 2] = 64'(1);
      total = 64'(1);
    end
    run = '0;
    for (i = 0; i <= BINS; i++) begin
      case (shape)
        SHAPE_NOISE: value = VAL_W'($urandom_range(ONE_Q16));
        // Starts above zero and ends short of one, so the top samples run off the end.
        SHAPE_SHIFTED: value = VAL_W'(3000 + run * 57000 / total);
        default: value = VAL_W'(run * ONE_Q16 / total);
      endcase
      queue_load(i, value);
      if (i < BINS) begin
        run += weight[WGT_AW'(i)];
      end
      if ($urandom_range(15) == 0) begin
        queue_load($urandom_range(127, BINS + 1), VAL_W'($urandom_range(ONE_Q16)));
      end
    end
  endtask

  task automatic queue_random_item();
    int unsigned      pick;
    logic [VAL_W-1:0] target;
    pick = $urandom_range(99);
    if (pick < 6) begin
      queue_load($urandom_range(BINS), VAL_W'($urandom_range(ONE_Q16)));
    end else if (pick < 9) begin
      queue_load($urandom_range(127, BINS + 1), VAL_W'($urandom_range(ONE_Q16)));
    end else if (pick < 21) begin
      // Fold onto a table value with its lowest bit cleared, in either half.
      target = planned_cdf[TAB_AW'($urandom_range(BINS))];
      queue_sample({1'($urandom_range(1)), target[X_W-1:1]});
    end else if (pick < 25) begin
      case ($urandom_range(3))
        0: queue_sample(16'h0000);
        1: queue_sample(16'h7FFF);
        2: queue_sample(16'h8000);
        default: queue_sample(16'hFFFF);
      endcase
    end else begin
      queue_sample(X_W'($urandom));
    end
  endtask

  // Waits until every queued item has been sent and every result has come back.
  task automatic wait_until_idle();
    do begin
      @(negedge clk_i);
    end while (items_to_send.size() != 0 || in_valid || offsets_due.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      REG_FILTER_MODE: mode_shadow = value[MODE_W-1:0];
      REG_HALF_WIDTH: half_width_shadow = value;
      REG_BIN_SIZE: bin_size_shadow = value;
      default: ;
    endcase
  endtask

  // Register writes only happen once the block has gone quiet.
  task automatic set_config(input logic [MODE_W-1:0] mode, input logic [CFG_W-1:0] hw,
                            input logic [CFG_W-1:0] bs);
    logic [CFG_W-1:0] mode_word;
    wait_until_idle();
    // The bits above the mode field carry noise.
    mode_word = CFG_W'($urandom);
    mode_word[MODE_W-1:0] = mode;
    write_reg(REG_FILTER_MODE, mode_word);
    write_reg(REG_HALF_WIDTH, hw);
    write_reg(REG_BIN_SIZE, bs);
  endtask

  // Stimulus sequence and end of run.
  initial begin
    int               phase, i, reloads;
    logic [MODE_W-1:0] mode;
    logic [CFG_W-1:0]  hw, bs;
    reloads = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset defaults over a linear table; stray loads past the end must not land.
    for (i = 0; i <= BINS; i++) begin
      queue_load(i, VAL_W'(i * 1024));
    end
    queue_load(BINS + 1, '0);
    queue_load(127, '0);
    queue_sample(16'h0000);
    queue_sample(16'h0001);
    queue_sample(16'h7FFF);
    queue_sample(16'h8000);
    queue_sample(16'h8001);
    queue_sample(16'hFFFF);
    queue_sample(16'h4000);
    queue_sample(16'h1234);
    // Folded value below the start of the first bin.
    queue_load(0, VAL_W'(2000));
    queue_sample(16'h0000);
    // Falling first bin.
    queue_load(0, VAL_W'(5000));
    queue_sample(16'h0000);
    queue_sample(16'h8000);
    queue_load(0, '0);
    // No bin found: the last bin is used and the fraction clamps to one.
    queue_load(BINS, VAL_W'(65000));
    queue_sample(16'hFFFF);
    // Flat last bin, then a falling one.
    queue_load(BINS - 1, VAL_W'(65000));
    queue_sample(16'hFFFF);
    queue_load(BINS - 1, VAL_W'(65200));
    queue_sample(16'h7FFF);
    queue_load(BINS - 1, VAL_W'((BINS - 1) * 1024));
    queue_load(BINS, ONE_Q16);
    // Largest bin size drives the magnitude into saturation.
    set_config(MODE_TABLE, HALF_WIDTH_RST, {CFG_W{1'b1}});
    queue_sample(16'h7FFF);
    queue_sample(16'hFFFF);
    // Box mode at both half width extremes.
    set_config(MODE_BOX, {CFG_W{1'b1}}, BIN_SIZE_RST);
    queue_sample(16'h0000);
    queue_sample(16'h7FFF);
    queue_sample(16'h8000);
    queue_sample(16'hFFFF);
    set_config(MODE_BOX, '0, BIN_SIZE_RST);
    queue_sample(16'hFFFF);
    // Dirac and the unused mode answer zero.
    set_config(MODE_DIRAC, HALF_WIDTH_RST, BIN_SIZE_RST);
    queue_sample(16'hFFFF);
    set_config(MODE_UNUSED, HALF_WIDTH_RST, BIN_SIZE_RST);
    queue_sample(16'h0001);

    // Random phases: each table phase reloads a fresh table shape.
    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        1, 5, 6, 10: mode = MODE_BOX;
        4: mode = MODE_DIRAC;
        7: mode = MODE_UNUSED;
        default: mode = MODE_TABLE;
      endcase
      case (phase % 3)
        0: hw = '1;
        1: hw = '0;
        default: hw = CFG_W'($urandom_range(32766, 1));
      endcase
      case (phase % 6)
        0: bs = BIN_SIZE_RST;
        1: bs = '1;
        2: bs = CFG_W'($urandom);
        3: bs = '0;
        4: bs = 15'd4096;
        default: bs = CFG_W'($urandom_range(600, 1));
      endcase
      set_config(mode, hw, bs);
      send_idle_pct = (phase < 4) ? 9 : (phase < 8) ? 79 : 0;
      recv_idle_pct = (phase < 4) ? 79 : (phase < 8) ? 9 : 0;
      if (mode == MODE_TABLE) begin
        queue_table(cdf_shape_e'(reloads % 4));
        reloads++;
      end
      for (i = 0; i < PHASE_ITEMS; i++) begin
        queue_random_item();
      end
    end

    wait_until_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  // Run limit, several times the slowest correct run.
  initial begin
    #2000000;
    $display("tb_top: errors");
    $finish;
  end

endmodule
